@@ rtl/core/button_debounce_autorepeat_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce and autorepeat block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_ASSERT_SVH

// same-cycle implication
`define BDA_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define BDA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/core/bda_pkg.sv @@
// ----------------------------------------------------------------------------
// bda_pkg
// Shared widths, register indexes, reset values and key code table.
// ----------------------------------------------------------------------------
package bda_pkg;

	localparam int BUTTONS_DEF   = 5;
	localparam int DIR_KEYS      = 4;
	localparam int DEBOUNCE_FULL = 10;
	localparam int SAMPLE_BITS   = 12;
	localparam int STEP_W        = 8;
	localparam int CNT_W         = 16;
	localparam int CODE_W        = 7;
	localparam int KEY_IDX_W     = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_UP         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_PRESS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_RELEASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_PRESS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_RELEASE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd7;

	localparam logic [STEP_W-1:0]      RST_STEP_UP         = 8'd1;
	localparam logic [STEP_W-1:0]      RST_STEP_DOWN       = 8'd1;
	localparam logic [SAMPLE_BITS-1:0] RST_UPPER_PRESS     = 12'd3595;
	localparam logic [SAMPLE_BITS-1:0] RST_UPPER_RELEASE   = 12'd3095;
	localparam logic [SAMPLE_BITS-1:0] RST_LOWER_PRESS     = 12'd500;
	localparam logic [SAMPLE_BITS-1:0] RST_LOWER_RELEASE   = 12'd1000;
	localparam logic [CNT_W-1:0]       RST_REPEAT_DELAY    = 16'd100;
	localparam logic [CNT_W-1:0]       RST_REPEAT_INTERVAL = 16'd10;

	localparam int NCODES = 9;
	localparam logic [CODE_W-1:0] KEY_CODES [NCODES] = '{
		7'h31, 7'h32, 7'h41, 7'h42, 7'h53, 7'h52, 7'h4C, 7'h55, 7'h44
	};

	typedef struct packed {
		logic [STEP_W-1:0]      step_up;
		logic [STEP_W-1:0]      step_down;
		logic [SAMPLE_BITS-1:0] upper_press;
		logic [SAMPLE_BITS-1:0] upper_release;
		logic [SAMPLE_BITS-1:0] lower_press;
		logic [SAMPLE_BITS-1:0] lower_release;
		logic [CNT_W-1:0]       repeat_delay;
		logic [CNT_W-1:0]       repeat_interval;
	} cfg_t;

	// keys without an entry in the table report code zero
	function automatic logic [CODE_W-1:0] key_code_f(input logic [KEY_IDX_W-1:0] idx);
		logic [CODE_W-1:0] code;
		code = '0;
		for (int i = 0; i < NCODES; i++) begin
			if (idx == KEY_IDX_W'(i))
				code = KEY_CODES[i];
		end
		return code;
	endfunction

endpackage

@@ rtl/core/button_debounce_autorepeat_unit.sv @@
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_unit
// Button debouncer with joystick direction keys and key autorepeat.
// ----------------------------------------------------------------------------
// Tick channel (tick_valid/tick_stall) carries raw_buttons, joystick_x and
// joystick_y once per tick. Key channel (key_valid/key_stall) returns one
// key press per transaction: key_code, last on the final press of the tick,
// and held_keys, the debounced state after that tick. A tick with no presses
// returns nothing. Configuration writes come over cfg_valid/cfg_ready with
// cfg_index and cfg_data, always ready; the user must make them only while
// the block is idle (unenforced). The first key of a tick passes deb_s1,
// pend_q and key_code; the rest follow one per cycle while key_stall is low.
// Ticks are taken every cycle while the emitter has room; a tick with n
// presses (at most 9 with default sizes) holds the single key output register
// for n transactions, setting the tick rate. Reset clears integrators,
// debounced state, hold and repeat counters, and loads the register
// defaults. A stalled key output holds its value and stalls ticks in turn.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_unit import bda_pkg::*; #(
	parameter int BUTTONS = BUTTONS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_valid,
	output logic                   tick_stall,
	input  logic [BUTTONS-1:0]     raw_buttons,
	input  logic [SAMPLE_BITS-1:0] joystick_x,
	input  logic [SAMPLE_BITS-1:0] joystick_y,
	output logic                   key_valid,
	input  logic                   key_stall,
	output logic [CODE_W-1:0]      key_code,
	output logic                   last,
	output logic [BUTTONS+DIR_KEYS-1:0] held_keys,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int KEYS  = BUTTONS + DIR_KEYS;
	localparam int RIGHT = BUTTONS;
	localparam int LEFT  = BUTTONS + 1;
	localparam int UP    = BUTTONS + 2;
	localparam int DOWN  = BUTTONS + 3;

	cfg_t            cfg_q;
	logic [KEYS-1:0] deb_q, deb_d;
	logic [KEYS-1:0] deb_s1, old_s1;
	logic            s1_valid_q;
	logic            s1_adv;
	logic            e_ready;
	logic            tick_fire;
	logic [BUTTONS-1:0] btn_set, btn_clr;
	logic [KEYS-1:0] rep_press;
	logic [KEYS-1:0] presses;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_up         <= RST_STEP_UP;
			cfg_q.step_down       <= RST_STEP_DOWN;
			cfg_q.upper_press     <= RST_UPPER_PRESS;
			cfg_q.upper_release   <= RST_UPPER_RELEASE;
			cfg_q.lower_press     <= RST_LOWER_PRESS;
			cfg_q.lower_release   <= RST_LOWER_RELEASE;
			cfg_q.repeat_delay    <= RST_REPEAT_DELAY;
			cfg_q.repeat_interval <= RST_REPEAT_INTERVAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP_UP:         cfg_q.step_up         <= cfg_data[STEP_W-1:0];
				REG_STEP_DOWN:       cfg_q.step_down       <= cfg_data[STEP_W-1:0];
				REG_UPPER_PRESS:     cfg_q.upper_press     <= cfg_data[SAMPLE_BITS-1:0];
				REG_UPPER_RELEASE:   cfg_q.upper_release   <= cfg_data[SAMPLE_BITS-1:0];
				REG_LOWER_PRESS:     cfg_q.lower_press     <= cfg_data[SAMPLE_BITS-1:0];
				REG_LOWER_RELEASE:   cfg_q.lower_release   <= cfg_data[SAMPLE_BITS-1:0];
				REG_REPEAT_DELAY:    cfg_q.repeat_delay    <= cfg_data[CNT_W-1:0];
				REG_REPEAT_INTERVAL: cfg_q.repeat_interval <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 0: debounce lanes and joystick thresholds
	assign tick_stall = s1_valid_q && !e_ready;
	assign tick_fire  = tick_valid && !tick_stall;
	assign s1_adv     = s1_valid_q && e_ready;

	for (genvar b = 0; b < BUTTONS; b++) begin : g_btn
		bda_button_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (tick_fire),
			.raw    (raw_buttons[b]),
			.cfg    (cfg_q),
			.set    (btn_set[b]),
			.clr    (btn_clr[b])
		);
	end

	always_comb begin
		deb_d = deb_q;
		for (int b = 0; b < BUTTONS; b++) begin
			if (btn_set[b])
				deb_d[b] = 1'b1;
			else if (btn_clr[b])
				deb_d[b] = 1'b0;
		end
		// set check first, so overlapping thresholds leave the key cleared
		if (joystick_x > cfg_q.upper_press)   deb_d[RIGHT] = 1'b1;
		if (joystick_x < cfg_q.upper_release) deb_d[RIGHT] = 1'b0;
		if (joystick_x < cfg_q.lower_press)   deb_d[LEFT]  = 1'b1;
		if (joystick_x > cfg_q.lower_release) deb_d[LEFT]  = 1'b0;
		if (joystick_y > cfg_q.upper_press)   deb_d[UP]    = 1'b1;
		if (joystick_y < cfg_q.upper_release) deb_d[UP]    = 1'b0;
		if (joystick_y < cfg_q.lower_press)   deb_d[DOWN]  = 1'b1;
		if (joystick_y > cfg_q.lower_release) deb_d[DOWN]  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (tick_fire) begin
				deb_q      <= deb_d;
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			deb_s1 <= deb_d;
			old_s1 <= deb_q;
		end
	end

	// stage 1: autorepeat lanes, merged with edge presses
	for (genvar k = 0; k < KEYS; k++) begin : g_key
		bda_repeat_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (s1_adv),
			.held   (deb_s1[k]),
			.cfg    (cfg_q),
			.press  (rep_press[k])
		);
	end

	assign presses = (deb_s1 & ~old_s1) | rep_press;

	bda_emitter #(
		.KEYS (KEYS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (s1_valid_q),
		.load_ready (e_ready),
		.presses    (presses),
		.held       (deb_s1),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key_code   (key_code),
		.last       (last),
		.held_keys  (held_keys)
	);

	`include "button_debounce_autorepeat_unit_assert.svh"

	`BDA_ASSERT_NOW(a_stall_cause, tick_stall, s1_valid_q && !e_ready && (key_valid || !e_ready), "tick stalled without a waiting tick")
	`BDA_ASSERT_NEXT(a_s1_hold, s1_valid_q && !e_ready, s1_valid_q && $stable(deb_s1), "waiting tick lost")
	`BDA_ASSERT_NEXT(a_state_follow, tick_fire, deb_s1 == deb_q, "debounced state and stage copy differ")

endmodule

@@ rtl/core/bda_button_lane.sv @@
// ----------------------------------------------------------------------------
// bda_button_lane
// Saturating integrator for one raw button; flags set and clear of its bit.
// ----------------------------------------------------------------------------
module bda_button_lane import bda_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic raw,
	input  cfg_t cfg,
	output logic set,
	output logic clr
);

	logic [STEP_W-1:0] integ_q;
	logic [STEP_W-1:0] integ_d;
	logic [STEP_W:0]   sum;

	assign sum = {1'b0, integ_q} + {1'b0, cfg.step_up};

	always_comb begin
		set     = 1'b0;
		clr     = 1'b0;
		integ_d = integ_q;
		if (raw) begin
			if (sum >= (STEP_W+1)'(DEBOUNCE_FULL)) begin
				integ_d = STEP_W'(DEBOUNCE_FULL);
				set     = 1'b1;
			end else begin
				integ_d = sum[STEP_W-1:0];
			end
		end else if (integ_q <= cfg.step_down) begin
			integ_d = '0;
			clr     = 1'b1;
		end else begin
			integ_d = integ_q - cfg.step_down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			integ_q <= '0;
		else if (en)
			integ_q <= integ_d;
	end

endmodule

@@ rtl/core/bda_repeat_lane.sv @@
// ----------------------------------------------------------------------------
// bda_repeat_lane
// Hold and repeat-phase counters of one key; flags autorepeat presses.
// ----------------------------------------------------------------------------
module bda_repeat_lane import bda_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic held,
	input  cfg_t cfg,
	output logic press
);

	logic [CNT_W-1:0] hold_q, hold_d, hold_inc;
	logic [CNT_W-1:0] phase_q, phase_d, phase_inc;

	assign hold_inc  = hold_q + 1'b1;
	assign phase_inc = phase_q + 1'b1;

	always_comb begin
		hold_d  = hold_q;
		phase_d = phase_q;
		press   = 1'b0;
		if (!held) begin
			hold_d  = '0;
			phase_d = '0;
		end else if (hold_q < cfg.repeat_delay) begin
			hold_d = hold_inc;
			if (hold_inc == cfg.repeat_delay) begin
				phase_d = '0;
				press   = 1'b1;
			end
		end else if (phase_inc >= cfg.repeat_interval) begin
			phase_d = '0;
			press   = 1'b1;
		end else begin
			phase_d = phase_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= '0;
			phase_q <= '0;
		end else if (en) begin
			hold_q  <= hold_d;
			phase_q <= phase_d;
		end
	end

endmodule

@@ rtl/core/bda_emitter.sv @@
// ----------------------------------------------------------------------------
// bda_emitter
// Merges the lane presses of a tick and sends one key code per transaction.
// ----------------------------------------------------------------------------
module bda_emitter import bda_pkg::*; #(
	parameter int KEYS = BUTTONS_DEF + DIR_KEYS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  logic [KEYS-1:0]   presses,
	input  logic [KEYS-1:0]   held,
	output logic              key_valid,
	input  logic              key_stall,
	output logic [CODE_W-1:0] key_code,
	output logic              last,
	output logic [KEYS-1:0]   held_keys
);

	localparam int IDX_W = $clog2(KEYS);

	logic [KEYS-1:0]   pend_q;
	logic [KEYS-1:0]   held_pend_q;
	logic [KEYS-1:0]   rest;
	logic [IDX_W-1:0]  pick_idx;
	logic              out_free;
	logic              out_load;
	logic              load;

	assign rest     = pend_q & (pend_q - 1'b1);
	assign out_free = !key_valid || !key_stall;
	assign out_load = out_free && (pend_q != '0);
	// take a new mask once the current one is empty or leaves with this transaction
	assign load_ready = (pend_q == '0) || (out_free && (rest == '0));
	assign load       = load_valid && load_ready;

	always_comb begin
		pick_idx = '0;
		for (int i = KEYS - 1; i >= 0; i--) begin
			if (pend_q[i])
				pick_idx = IDX_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			key_valid <= 1'b0;
		end else begin
			if (load)
				pend_q <= presses;
			else if (out_load)
				pend_q <= rest;
			if (out_load)
				key_valid <= 1'b1;
			else if (out_free)
				key_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			held_pend_q <= held;
		if (out_load) begin
			key_code  <= key_code_f(KEY_IDX_W'(pick_idx));
			last      <= (rest == '0);
			held_keys <= held_pend_q;
		end
	end

	`include "button_debounce_autorepeat_unit_assert.svh"

	`BDA_ASSERT_NOW(a_more_pending, key_valid && !last, pend_q != '0, "non-last key without pending presses")
	`BDA_ASSERT_NOW(a_no_drop, load && (pend_q != '0), out_free && (rest == '0), "pending presses overwritten")
	`BDA_ASSERT_NEXT(a_tick_burst, key_valid && !key_stall && !last, key_valid && (held_keys == $past(held_keys)), "tick results split")

endmodule
